[src/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// shared types and constants for the greedy box suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  localparam int unsigned GBN_MAX_BOXES = 64;
  localparam logic [15:0] GBN_THR_RESET = 16'd26214;
  // pipeline depth of the overlap test unit
  localparam int unsigned GBN_IOU_LAT   = 6;
  // inclusive pixel convention, one pixel in Q12.4
  localparam logic signed [17:0] GBN_ONE_PIXEL = 18'sd16;

  typedef struct packed {
    logic [15:0]        score;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } box_t;

  typedef struct packed {
    logic valid;  // box present and not suppressed
    logic kept;   // box already selected as a survivor
    box_t box;
  } ent_t;

  typedef struct packed {
    logic ins;  // sorted insert of a new box
    logic rot;  // rotate ring toward the head
    logic clr;  // drop all entries
  } cell_ctrl_t;

  typedef struct packed {
    logic adv;
    logic clr;
  } pipe_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } gbn_state_e;

endpackage

`default_nettype wire

[src/gbn_cell.sv]
// ----------------------------------------------------------------------------
// gbn_cell
// one slot of the sorted box chain
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_cell import gbn_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  box_t       new_box_i,
  input  wire        prev_less_i,
  input  ent_t       prev_ent_i,
  input  ent_t       next_ent_i,
  output ent_t       ent_o,
  output logic       less_o
);

  logic valid_q, valid_d;
  logic kept_q, kept_d;
  box_t box_q, box_d;

  // stable order: a new box goes behind equal scores
  assign less_o = !valid_q || (box_q.score < new_box_i.score);

  always_comb begin
    valid_d = valid_q;
    kept_d  = kept_q;
    box_d   = box_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
      kept_d  = 1'b0;
    end else if (ctrl_i.rot) begin
      valid_d = next_ent_i.valid;
      kept_d  = next_ent_i.kept;
      box_d   = next_ent_i.box;
    end else if (ctrl_i.ins && less_o) begin
      if (prev_less_i) begin
        valid_d = prev_ent_i.valid;
        kept_d  = prev_ent_i.kept;
        box_d   = prev_ent_i.box;
      end else begin
        valid_d = 1'b1;
        kept_d  = 1'b0;
        box_d   = new_box_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kept_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      kept_q  <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign ent_o = '{valid: valid_q, kept: kept_q, box: box_q};

endmodule

`default_nettype wire

[src/gbn_iou.sv]
// ----------------------------------------------------------------------------
// gbn_iou
// pipelined overlap test of ring entries against the selected box
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_iou import gbn_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  pipe_ctrl_t  ctrl_i,
  input  ent_t        ent_i,
  input  wire         test_i,
  input  box_t        a_box_i,
  input  wire  [15:0] thr_i,
  output ent_t        ent_o
);

  ent_t e1_q, e2_q, e3_q, e4_q, e5_q, e6_q;
  logic t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;

  logic [16:0]        iw_q, ih_q;
  logic signed [17:0] wa_q, ha_q, wb_q, hb_q;
  logic [32:0]        inter3_q, inter4_q, inter5_q, inter6_q;
  logic signed [35:0] aa_q, ab_q, uni_q;
  logic signed [34:0] phi_q;
  logic [33:0]        plo_q;
  logic signed [53:0] rhs_q;

  logic signed [15:0] ix_hi, ix_lo, iy_hi, iy_lo;
  logic signed [17:0] iw_raw, ih_raw, wa_d, ha_d, wb_d, hb_d;
  logic signed [53:0] lhs;
  logic               survive;

  always_comb begin
    ix_hi  = (a_box_i.x2 < e1_q.box.x2) ? a_box_i.x2 : e1_q.box.x2;
    ix_lo  = (a_box_i.x1 > e1_q.box.x1) ? a_box_i.x1 : e1_q.box.x1;
    iy_hi  = (a_box_i.y2 < e1_q.box.y2) ? a_box_i.y2 : e1_q.box.y2;
    iy_lo  = (a_box_i.y1 > e1_q.box.y1) ? a_box_i.y1 : e1_q.box.y1;
    iw_raw = 18'(ix_hi) - 18'(ix_lo) + GBN_ONE_PIXEL;
    ih_raw = 18'(iy_hi) - 18'(iy_lo) + GBN_ONE_PIXEL;
    wa_d   = 18'(a_box_i.x2) - 18'(a_box_i.x1) + GBN_ONE_PIXEL;
    ha_d   = 18'(a_box_i.y2) - 18'(a_box_i.y1) + GBN_ONE_PIXEL;
    wb_d   = 18'(e1_q.box.x2) - 18'(e1_q.box.x1) + GBN_ONE_PIXEL;
    hb_d   = 18'(e1_q.box.y2) - 18'(e1_q.box.y1) + GBN_ONE_PIXEL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0; e2_q <= '0; e3_q <= '0; e4_q <= '0; e5_q <= '0; e6_q <= '0;
      t1_q <= 1'b0; t2_q <= 1'b0; t3_q <= 1'b0;
      t4_q <= 1'b0; t5_q <= 1'b0; t6_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      e1_q <= '0; e2_q <= '0; e3_q <= '0; e4_q <= '0; e5_q <= '0; e6_q <= '0;
      t1_q <= 1'b0; t2_q <= 1'b0; t3_q <= 1'b0;
      t4_q <= 1'b0; t5_q <= 1'b0; t6_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      e1_q <= ent_i; t1_q <= test_i;
      e2_q <= e1_q;  t2_q <= t1_q;
      e3_q <= e2_q;  t3_q <= t2_q;
      e4_q <= e3_q;  t4_q <= t3_q;
      e5_q <= e4_q;  t5_q <= t4_q;
      e6_q <= e5_q;  t6_q <= t5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      // stage 2: extents, intersection clamped at zero
      iw_q <= iw_raw[17] ? 17'd0 : iw_raw[16:0];
      ih_q <= ih_raw[17] ? 17'd0 : ih_raw[16:0];
      wa_q <= wa_d; ha_q <= ha_d; wb_q <= wb_d; hb_q <= hb_d;
      // stage 3: areas, full-extent boxes need 33 bits of intersection
      inter3_q <= 33'(iw_q) * 33'(ih_q);
      aa_q     <= 36'(wa_q) * 36'(ha_q);
      ab_q     <= 36'(wb_q) * 36'(hb_q);
      // stage 4: union
      inter4_q <= inter3_q;
      uni_q    <= aa_q + ab_q - $signed({3'd0, inter3_q});
      // stage 5: threshold times union in two partial products
      inter5_q <= inter4_q;
      phi_q    <= 35'($signed({1'b0, thr_i})) * 35'($signed(uni_q[35:18]));
      plo_q    <= 34'(thr_i) * 34'(uni_q[17:0]);
      // stage 6: recombine
      inter6_q <= inter5_q;
      rhs_q    <= (54'(phi_q) <<< 18) + $signed({20'd0, plo_q});
    end
  end

  assign lhs     = $signed({5'd0, inter6_q, 16'd0});
  assign survive = lhs <= rhs_q;

  always_comb begin
    ent_o       = e6_q;
    ent_o.valid = e6_q.valid && (!t6_q || survive);
  end

endmodule

`default_nettype wire

[src/greedy_box_nms.sv]
// ----------------------------------------------------------------------------
// greedy_box_nms
// greedy non-maximum suppression over a set of scored boxes
// ----------------------------------------------------------------------------
// Boxes load one per cycle into a chain of MAX_BOXES cells that keeps them
// sorted by descending score (ties in arrival order); boxes past capacity are
// dropped and out_overflow_o is raised on every result of that set. The box
// with in_last_i stops loading. The chain then closes into a ring through a
// six-stage overlap test pipeline, ring length R = MAX_BOXES + 6. Each pass
// rotates the ring once: the first live unselected box is selected and every
// later live box is tested against it. Passes repeat until one selects
// nothing. One last pass emits the survivors in score order, held while
// out_stall_i is high; out_last_o marks the final one. Input is stalled from
// in_last_i until that last pass finishes; the final result may still wait
// in the output register while the next set loads. The threshold write is
// taken any time but is meant to change only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_nms import gbn_pkg::*; #(
  parameter int unsigned MAX_BOXES = GBN_MAX_BOXES
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] in_score_i,
  input  wire  [15:0] in_x1_i,
  input  wire  [15:0] in_y1_i,
  input  wire  [15:0] in_x2_i,
  input  wire  [15:0] in_y2_i,
  input  wire         in_last_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] out_score_o,
  output logic [15:0] out_x1_o,
  output logic [15:0] out_y1_o,
  output logic [15:0] out_x2_o,
  output logic [15:0] out_y2_o,
  output logic        out_last_o,
  output logic        out_overflow_o
);

  localparam int unsigned RING   = MAX_BOXES + GBN_IOU_LAT;
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned STEP_W = $clog2(RING);

  gbn_state_e state_q, state_d;

  logic [15:0]       thr_q;
  logic [CNT_W-1:0]  cnt_q, kept_cnt_q, emit_cnt_q;
  logic [STEP_W-1:0] step_q;
  logic              ovf_q, have_a_q;
  box_t              a_q;

  logic in_acc, full, step_end, cap, emit_adv, emit_take;
  cell_ctrl_t cctl;
  pipe_ctrl_t pctl;
  ent_t       pipe_in, tail_ent;
  logic       pipe_test;
  box_t       new_box;

  ent_t cell_ent  [MAX_BOXES];
  logic cell_less [MAX_BOXES];

  logic        out_valid_q, out_last_q, out_ovf_q;
  box_t        out_box_q;

  assign new_box  = '{score: in_score_i, x1: in_x1_i, y1: in_y1_i,
                      x2: in_x2_i, y2: in_y2_i};
  assign full     = (cnt_q == CNT_W'(MAX_BOXES));
  assign in_acc   = in_valid_i && !in_stall_o;
  assign step_end = (step_q == STEP_W'(RING - 1));

  // first live, not yet selected box of the pass becomes the reference
  assign cap       = !have_a_q && cell_ent[0].valid && !cell_ent[0].kept;
  assign emit_adv  = !out_valid_q || !out_stall_i;
  assign emit_take = cell_ent[0].valid && cell_ent[0].kept;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_acc && in_last_i) state_d = ST_SCAN;
      ST_SCAN: if (step_end && !have_a_q && !cap) state_d = ST_EMIT;
      ST_EMIT: if (step_end && emit_adv) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    cctl       = '0;
    pctl       = '0;
    pipe_test  = 1'b0;
    pipe_in    = cell_ent[0];
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        cctl.ins   = in_acc && !full;
      end
      ST_SCAN: begin
        cctl.rot     = 1'b1;
        pctl.adv     = 1'b1;
        pipe_in.kept = cell_ent[0].kept || cap;
        pipe_test    = have_a_q && cell_ent[0].valid && !cell_ent[0].kept;
      end
      ST_EMIT: begin
        cctl.rot = emit_adv;
        pctl.adv = emit_adv;
        cctl.clr = step_end && emit_adv;
        pctl.clr = step_end && emit_adv;
      end
      default: ;
    endcase
  end

  // sorted chain, closed into a ring through the test pipeline
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    gbn_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctl),
      .new_box_i   (new_box),
      .prev_less_i ((i == 0) ? 1'b0 : cell_less[(i == 0) ? 0 : i - 1]),
      .prev_ent_i  ((i == 0) ? ent_t'('0) : cell_ent[(i == 0) ? 0 : i - 1]),
      .next_ent_i  ((i == MAX_BOXES - 1) ? tail_ent
                                         : cell_ent[(i == MAX_BOXES - 1) ? i : i + 1]),
      .ent_o       (cell_ent[i]),
      .less_o      (cell_less[i])
    );
  end

  gbn_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pctl),
    .ent_i   (pipe_in),
    .test_i  (pipe_test),
    .a_box_i (a_q),
    .thr_i   (thr_q),
    .ent_o   (tail_ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      thr_q      <= GBN_THR_RESET;
      cnt_q      <= '0;
      kept_cnt_q <= '0;
      emit_cnt_q <= '0;
      step_q     <= '0;
      ovf_q      <= 1'b0;
      have_a_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) ovf_q <= 1'b1;
            else      cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (cap) begin
            have_a_q   <= 1'b1;
            kept_cnt_q <= kept_cnt_q + CNT_W'(1);
          end
          if (step_end) begin
            step_q   <= '0;
            have_a_q <= 1'b0;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit_adv) begin
            if (emit_take) emit_cnt_q <= emit_cnt_q + CNT_W'(1);
            if (step_end) begin
              step_q     <= '0;
              cnt_q      <= '0;
              kept_cnt_q <= '0;
              emit_cnt_q <= '0;
              ovf_q      <= 1'b0;
            end else begin
              step_q <= step_q + STEP_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // reference box of the current pass
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && cap) a_q <= cell_ent[0].box;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && emit_adv) begin
      out_valid_q <= emit_take;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_adv && emit_take) begin
      out_box_q  <= cell_ent[0].box;
      out_last_q <= (emit_cnt_q == kept_cnt_q - CNT_W'(1));
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_score_o    = out_box_q.score;
  assign out_x1_o       = out_box_q.x1;
  assign out_y1_o       = out_box_q.y1;
  assign out_x2_o       = out_box_q.x2;
  assign out_y2_o       = out_box_q.y2;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_ovf_q;

endmodule

`default_nettype wire

[src/gbn_checker.sv]
// ----------------------------------------------------------------------------
// gbn_checker
// port-level checks for the greedy box suppression block
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        in_last_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [15:0] out_score_o,
  input wire        out_last_o
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_score_o))
    else $error("stalled result changed");

  // the closing box of a set stops loading
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_last_i |=> in_stall_o)
    else $error("input taken after closing box");

  // input stays stalled while any result but a set's final one is taken
  a_emit_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |-> in_stall_o)
    else $error("input open during emission");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (.*);

`default_nettype wire
